FILE: hw/rtl/txcw_pkg.sv
// ----------------------------------------------------------------------------
// txcw_pkg
// Shared constants and command codes of the text console writer.
// ----------------------------------------------------------------------------
package txcw_pkg;

    // default screen geometry
    localparam int TXCW_COLUMNS = 80;
    localparam int TXCW_ROWS    = 25;

    // cell layout: character low byte, attribute high byte
    localparam int CELL_W = 16;

    // blank fill character and attribute after reset
    localparam logic [7:0] BLANK_CHAR       = 8'h20;
    localparam logic [7:0] TEXT_COLOR_RESET = 8'h07;

    // command codes carried in s_tuser
    typedef enum logic [1:0] {
        CMD_PUT_CHAR = 2'd0,
        CMD_PUT_AT   = 2'd1,
        CMD_READ     = 2'd2,
        CMD_CLEAR    = 2'd3
    } cmd_t;

endpackage

FILE: hw/rtl/txcw_ram.sv
// ----------------------------------------------------------------------------
// txcw_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module txcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one access per cycle, read data on the next cycle
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

FILE: hw/rtl/text_console_writer_unit.sv
// ----------------------------------------------------------------------------
// text_console_writer_unit
// Character-cell screen with cursor, kept in one RAM with a ring row offset.
// ----------------------------------------------------------------------------
// Sequence: an accepted item goes through EXEC, then RDWAIT for an on-screen
//   read, SWEEP (COLUMNS cells when a put-char scrolls, all cells for a clear)
//   and DONE, where the result waits on m_tready until the output register is
//   free. Items run one at a time, the steps in turn on one RAM port.
// Reset: cursor and row offset home, color 7; a clearing pass over all
//   ROWS*COLUMNS cells blanks the RAM while no item is accepted.
// ----------------------------------------------------------------------------
module text_console_writer_unit
    import txcw_pkg::*;
#(
    parameter int COLUMNS = TXCW_COLUMNS,
    parameter int ROWS    = TXCW_ROWS
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: text_color
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] char_code, [15:8] entry_color, [22:16] col_in, [27:23] row_in
    input  logic [31:0] s_tdata,
    // [1:0] cmd
    input  logic [1:0]  s_tuser,
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    // [15:0] entry_out, [22:16] cursor_col, [27:23] cursor_row,
    // [28] scrolled, [29] bad_position
    output logic [31:0] m_tdata
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_EXEC,
        ST_RDWAIT,
        ST_DONE
    } state_t;

    state_t            state_reg;
    logic              pend_reg;
    logic [AW-1:0]     sweep_addr_reg;
    logic [AW-1:0]     sweep_end_reg;
    logic [7:0]        blank_color_reg;
    logic [7:0]        text_color_reg;
    logic [CW-1:0]     cur_col_reg;
    logic [RW-1:0]     cur_row_reg;
    logic [RW-1:0]     top_reg;

    // latched input item
    cmd_t              cmd_reg;
    logic [7:0]        char_reg;
    logic [7:0]        ecolor_reg;
    logic [6:0]        col_in_reg;
    logic [4:0]        row_in_reg;

    // pending result
    logic [15:0]       res_entry_reg;
    logic              res_scrolled_reg;
    logic              res_bad_reg;

    logic              m_valid_reg;
    logic [31:0]       m_data_reg;

    // RAM port
    logic              mem_we;
    logic [AW-1:0]     mem_addr;
    logic [CELL_W-1:0] mem_wdata;
    logic [CELL_W-1:0] mem_rdata;

    logic              on_screen;
    logic [RW-1:0]     cur_prow;
    logic [RW-1:0]     pos_prow;
    logic [AW-1:0]     cur_addr;
    logic [AW-1:0]     pos_addr;
    logic              out_free;
    logic              at_last_col;
    logic              at_last_row;
    logic              scroll_now;
    logic              pos_bad;

    // logical row to physical row through the ring offset
    function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] r,
                                               input logic [RW-1:0] top);
        logic [RW:0] s;
        s = {1'b0, r} + {1'b0, top};
        if (s >= (RW+1)'(ROWS)) begin
            s = s - (RW+1)'(ROWS);
        end
        return s[RW-1:0];
    endfunction

    // address generation
    assign on_screen = ({1'b0, col_in_reg} < 8'(COLUMNS)) && ({1'b0, row_in_reg} < 6'(ROWS));
    assign cur_prow  = phys_row(cur_row_reg, top_reg);
    assign pos_prow  = phys_row(row_in_reg[RW-1:0], top_reg);
    assign cur_addr  = AW'(cur_prow) * AW'(COLUMNS) + AW'(cur_col_reg);
    assign pos_addr  = AW'(pos_prow) * AW'(COLUMNS) + AW'(col_in_reg[CW-1:0]);

    // cursor wrap and result flags
    assign at_last_col = (cur_col_reg == CW'(COLUMNS - 1));
    assign at_last_row = (cur_row_reg == RW'(ROWS - 1));
    assign scroll_now  = (cmd_reg == CMD_PUT_CHAR) && at_last_col && at_last_row;
    assign pos_bad     = (cmd_reg inside {CMD_PUT_AT, CMD_READ}) && !on_screen;

    assign out_free = !m_valid_reg || m_tready;

    // RAM access select
    always_comb begin
        mem_we    = 1'b0;
        mem_addr  = pos_addr;
        mem_wdata = {ecolor_reg, char_reg};
        case (state_reg)
            ST_SWEEP: begin
                mem_we    = 1'b1;
                mem_addr  = sweep_addr_reg;
                mem_wdata = {blank_color_reg, BLANK_CHAR};
            end
            ST_EXEC: begin
                case (cmd_reg)
                    CMD_PUT_CHAR: begin
                        mem_we    = 1'b1;
                        mem_addr  = cur_addr;
                        mem_wdata = {text_color_reg, char_reg};
                    end
                    CMD_PUT_AT: begin
                        mem_we = on_screen;
                    end
                    default: begin
                        mem_we = 1'b0;
                    end
                endcase
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    txcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .aclk  (aclk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // sequencer, cursor, ring offset and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_SWEEP;
            pend_reg        <= 1'b0;
            sweep_addr_reg  <= '0;
            sweep_end_reg   <= AW'(CELLS - 1);
            blank_color_reg <= TEXT_COLOR_RESET;
            text_color_reg  <= TEXT_COLOR_RESET;
            cur_col_reg     <= '0;
            cur_row_reg     <= '0;
            top_reg         <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                text_color_reg <= cfg_wr_data;
            end
            // output valid: set when a result is loaded, dropped when taken
            if (state_reg == ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_SWEEP: begin
                    sweep_addr_reg <= sweep_addr_reg + AW'(1);
                    if (sweep_addr_reg == sweep_end_reg) begin
                        state_reg <= pend_reg ? ST_DONE : ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_tvalid) begin
                        cmd_reg    <= cmd_t'(s_tuser);
                        char_reg   <= s_tdata[7:0];
                        ecolor_reg <= s_tdata[15:8];
                        col_in_reg <= s_tdata[22:16];
                        row_in_reg <= s_tdata[27:23];
                        state_reg  <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    res_entry_reg    <= '0;
                    res_scrolled_reg <= scroll_now;
                    res_bad_reg      <= pos_bad;
                    pend_reg         <= 1'b1;
                    case (cmd_reg)
                        CMD_PUT_CHAR: begin
                            if (at_last_col) begin
                                cur_col_reg <= '0;
                                if (at_last_row) begin
                                    // old top row becomes the new bottom row: blank it
                                    top_reg <= (top_reg == RW'(ROWS - 1)) ? '0
                                             : top_reg + RW'(1);
                                    sweep_addr_reg  <= AW'(top_reg) * AW'(COLUMNS);
                                    sweep_end_reg   <= AW'(top_reg) * AW'(COLUMNS)
                                                     + AW'(COLUMNS - 1);
                                    blank_color_reg <= text_color_reg;
                                    state_reg       <= ST_SWEEP;
                                end else begin
                                    cur_row_reg <= cur_row_reg + RW'(1);
                                    state_reg   <= ST_DONE;
                                end
                            end else begin
                                cur_col_reg <= cur_col_reg + CW'(1);
                                state_reg   <= ST_DONE;
                            end
                        end
                        CMD_PUT_AT: begin
                            state_reg <= ST_DONE;
                        end
                        CMD_READ: begin
                            state_reg <= on_screen ? ST_RDWAIT : ST_DONE;
                        end
                        default: begin
                            // clear: home cursor and offset, blank every cell
                            cur_col_reg     <= '0;
                            cur_row_reg     <= '0;
                            top_reg         <= '0;
                            sweep_addr_reg  <= '0;
                            sweep_end_reg   <= AW'(CELLS - 1);
                            blank_color_reg <= text_color_reg;
                            state_reg       <= ST_SWEEP;
                        end
                    endcase
                end
                ST_RDWAIT: begin
                    res_entry_reg <= mem_rdata;
                    state_reg     <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_free) begin
                        m_data_reg  <= {2'b00, res_bad_reg, res_scrolled_reg,
                                        5'(cur_row_reg), 7'(cur_col_reg), res_entry_reg};
                        pend_reg    <= 1'b0;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

FILE: sim/tb_text_console_writer_unit.sv
// ----------------------------------------------------------------------------
// tb_text_console_writer_unit
// Self-checking bench for the text console writer. A behavioral screen model
// (cell array, cursor, text color) predicts one result per accepted command,
// and every result item is compared field by field with the oldest
// prediction. Stimulus is a directed opening (corner cells, out-of-range
// positions, control characters, clear after a color change) and then
// put-char-heavy random runs that walk the cursor down the screen, under
// three handshake idling profiles, one long output stall and one full drain.
// ----------------------------------------------------------------------------
module tb_text_console_writer_unit;
    import txcw_pkg::*;

    localparam int COLS  = TXCW_COLUMNS;
    localparam int ROWS  = TXCW_ROWS;
    localparam int CELLS = COLS * ROWS;

    // result fields carried in m_tdata, compared one by one
    typedef struct packed {
        logic [15:0] entry;
        logic [6:0]  col;
        logic [4:0]  row;
        logic        scrolled;
        logic        bad;
    } console_result_t;

    // screen model and store of predicted results
    class console_scoreboard;
        logic [15:0]     cells [CELLS];
        logic [6:0]      cur_col;
        logic [4:0]      cur_row;
        logic [7:0]      text_color;
        console_result_t predicted_q [$];
        int              errors;
        int              results_seen;

        function new();
            text_color   = TEXT_COLOR_RESET;
            cur_col      = '0;
            cur_row      = '0;
            errors       = 0;
            results_seen = 0;
            blank_screen();
        endfunction

        function void blank_screen();
            for (int i = 0; i < CELLS; i++) begin
                cells[i] = {text_color, BLANK_CHAR};
            end
        endfunction

        function void set_color(logic [7:0] color);
            text_color = color;
        endfunction

        function int pending();
            return predicted_q.size();
        endfunction

        // apply one accepted command and queue the result it must produce
        function void note_item(cmd_t cmd, logic [7:0] ch, logic [7:0] ec,
                                logic [6:0] col, logic [4:0] row);
            console_result_t r;
            logic            on_screen;
            r = '0;
            on_screen = (col < COLS) && (row < ROWS);
            case (cmd)
                CMD_PUT_CHAR: begin
                    cells[cur_row * COLS + cur_col] = {text_color, ch};
                    if (cur_col == COLS - 1) begin
                        cur_col = '0;
                        if (cur_row == ROWS - 1) begin
                            // shift up one row, blank the bottom row
                            for (int i = 0; i < CELLS - COLS; i++) begin
                                cells[i] = cells[i + COLS];
                            end
                            for (int i = CELLS - COLS; i < CELLS; i++) begin
                                cells[i] = {text_color, BLANK_CHAR};
                            end
                            r.scrolled = 1'b1;
                        end else begin
                            cur_row = cur_row + 1'b1;
                        end
                    end else begin
                        cur_col = cur_col + 1'b1;
                    end
                end
                CMD_PUT_AT: begin
                    if (on_screen) cells[row * COLS + col] = {ec, ch};
                    else r.bad = 1'b1;
                end
                CMD_READ: begin
                    if (on_screen) r.entry = cells[row * COLS + col];
                    else r.bad = 1'b1;
                end
                default: begin
                    blank_screen();
                    cur_col = '0;
                    cur_row = '0;
                end
            endcase
            r.col = cur_col;
            r.row = cur_row;
            predicted_q.push_back(r);
        endfunction

        // one line per mismatch; printing is capped, counting is not
        task report(string field, longint unsigned got, longint unsigned want);
            errors++;
            if (errors <= 40) begin
                $display("t=%0t result %0d %s: got 0x%0h, expected 0x%0h",
                         $time, results_seen, field, got, want);
            end
        endtask

        task check_result(logic [31:0] d);
            console_result_t want;
            results_seen++;
            if (predicted_q.size() == 0) begin
                report("unexpected item", d, 0);
            end else begin
                want = predicted_q.pop_front();
                if (d[15:0] !== want.entry)    report("entry_out", d[15:0], want.entry);
                if (d[22:16] !== want.col)     report("cursor_col", d[22:16], want.col);
                if (d[27:23] !== want.row)     report("cursor_row", d[27:23], want.row);
                if (d[28] !== want.scrolled)   report("scrolled", d[28], want.scrolled);
                if (d[29] !== want.bad)        report("bad_position", d[29], want.bad);
            end
        endtask
    endclass

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [7:0]  cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;

    console_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    int recv_hold_left;

    text_console_writer_unit u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    // clock
    initial aclk = 1'b0;
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // run limit, well above the slowest legal run
    initial begin
        #2400000;
        $display("tb_text_console_writer_unit: errors");
        $finish;
    end

    // result side: random stalls, plus a long hold when requested
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (recv_hold_left > 0) begin
                m_tready <= 1'b0;
                recv_hold_left--;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // check every accepted result item
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    // offer one item, hold it until accepted; entered and left at a falling edge
    task automatic send_item(cmd_t cmd, logic [7:0] ch, logic [7:0] ec,
                             logic [6:0] col, logic [4:0] row);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {4'b0, row, col, ec, ch};
        do @(posedge aclk); while (!s_tready);
        sb.note_item(cmd, ch, ec, col, row);
        @(negedge aclk);
    endtask

    // withdraw the offer, then wait until every predicted result has come
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
    endtask

    // color register write while the block is idle
    task automatic write_color(logic [7:0] color);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= color;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        sb.set_color(color);
    endtask

    // random commands; clears are rare so the cursor walks well down the screen
    task automatic random_items(int n, int put_char_pct, int clear_pm);
        cmd_t       cmd;
        logic [7:0] ch;
        logic [7:0] ec;
        logic [6:0] col;
        logic [4:0] row;
        int         r;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(99);
            if (int'($urandom_range(999)) < clear_pm) cmd = CMD_CLEAR;
            else if (r < put_char_pct) cmd = CMD_PUT_CHAR;
            else if (r < put_char_pct + (100 - put_char_pct) * 2 / 5) cmd = CMD_PUT_AT;
            else cmd = CMD_READ;
            ch = 8'($urandom_range(255));
            ec = 8'($urandom_range(255));
            if ($urandom_range(99) < 15) begin
                col = 7'($urandom_range(127));
                row = 5'($urandom_range(31));
            end else begin
                col = 7'($urandom_range(COLS - 1));
                // favor the cursor row, where recent put-chars landed
                row = ($urandom_range(99) < 30) ? sb.cur_row : 5'($urandom_range(ROWS - 1));
            end
            send_item(cmd, ch, ec, col, row);
        end
    endtask

    // main sequence
    initial begin
        sb             = new();
        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = CMD_PUT_CHAR;
        send_idle_pct  = 8;
        recv_idle_pct  = 49;
        recv_hold_left = 0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: corners, out-of-range positions, odd bytes
        send_item(CMD_READ,     8'h00, 8'h00, 7'd0,       5'd0);
        send_item(CMD_READ,     8'h00, 8'h00, 7'(COLS-1), 5'(ROWS-1));
        send_item(CMD_PUT_AT,   8'h00, 8'h00, 7'd0,       5'd0);
        send_item(CMD_PUT_AT,   8'hFF, 8'hFF, 7'(COLS-1), 5'(ROWS-1));
        send_item(CMD_READ,     8'h00, 8'h00, 7'd0,       5'd0);
        send_item(CMD_READ,     8'hFF, 8'hFF, 7'(COLS-1), 5'(ROWS-1));
        send_item(CMD_PUT_AT,   8'h55, 8'hAA, 7'(COLS),   5'd0);
        send_item(CMD_PUT_AT,   8'h55, 8'hAA, 7'd0,       5'(ROWS));
        send_item(CMD_PUT_AT,   8'hFF, 8'hFF, 7'h7F,      5'h1F);
        send_item(CMD_READ,     8'h00, 8'h00, 7'(COLS),   5'd0);
        send_item(CMD_READ,     8'h00, 8'h00, 7'd0,       5'(ROWS));
        send_item(CMD_READ,     8'h00, 8'h00, 7'h7F,      5'h1F);
        // control characters are stored like any other byte
        send_item(CMD_PUT_CHAR, 8'h0A, 8'h00, 7'd0,       5'd0);
        send_item(CMD_PUT_CHAR, 8'h00, 8'h00, 7'd0,       5'd0);
        send_item(CMD_PUT_CHAR, 8'hFF, 8'hFF, 7'h7F,      5'h1F);
        send_item(CMD_READ,     8'h00, 8'h00, 7'd0,       5'd0);
        send_item(CMD_READ,     8'h00, 8'h00, 7'd2,       5'd0);

        // clear after a color change fills with the new color
        wait_drained();
        write_color(8'h1E);
        send_item(CMD_CLEAR,    8'h00, 8'h00, 7'd0,       5'd0);
        send_item(CMD_READ,     8'h00, 8'h00, 7'(COLS-1), 5'(ROWS-1));
        send_item(CMD_READ,     8'h00, 8'h00, 7'd0,       5'd0);
        send_item(CMD_PUT_CHAR, 8'h41, 8'h00, 7'd0,       5'd0);
        send_item(CMD_READ,     8'h00, 8'h00, 7'd0,       5'd0);

        // random, first profile; long output hold in the middle
        wait_drained();
        write_color(8'hFF);
        random_items(250, 93, 0);
        recv_hold_left = 400;
        random_items(300, 93, 0);

        // random, profiles swapped; full drain in the middle
        wait_drained();
        send_idle_pct = 49;
        recv_idle_pct = 8;
        write_color(8'h00);
        random_items(200, 93, 0);
        wait_drained();
        random_items(200, 93, 0);

        // random, no idling; then clears come back in
        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_color(8'($urandom_range(255)));
        random_items(150, 70, 0);
        wait_drained();
        write_color(8'($urandom_range(255)));
        random_items(100, 60, 5);

        wait_drained();
        repeat (100) @(negedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb_text_console_writer_unit: clean");
        end else begin
            $display("tb_text_console_writer_unit: errors");
        end
        $finish;
    end

endmodule
